FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define PIDC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset
`define PIDC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hw/rtl/pidc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pidc_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OLIM   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ILIM   = 3'd5;

    // Control law selection
    typedef enum logic [2:0] {
        MODE_POSITIONAL  = 3'd0,
        MODE_INCREMENTAL = 3'd1,
        MODE_PD_GYRO     = 3'd2,
        MODE_POS_DELTA   = 3'd3,
        MODE_CHASSIS     = 3'd4
    } pidc_mode_t;

    // Product slot in the multiply sequence
    typedef enum logic [1:0] {
        MUL_P = 2'd0,
        MUL_I = 2'd1,
        MUL_D = 2'd2
    } pidc_mul_slot_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_DIFF2,
        ST_DECIDE,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_INTEG,
        ST_INTEG_CLAMP,
        ST_SUM_PI,
        ST_SUM_D,
        ST_SUM_ACC,
        ST_CLAMP_OUT,
        ST_DONE
    } pidc_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pidc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample request channel: setpoint, feedback and gyro rate
interface pidc_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [DATA_WIDTH-1:0] setpoint;
    logic signed [DATA_WIDTH-1:0] feedback;
    logic signed [DATA_WIDTH-1:0] external_derivative;

    modport source (
        output valid, func, setpoint, feedback, external_derivative,
        input  ready
    );

    modport sink (
        input  valid, func, setpoint, feedback, external_derivative,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/pidc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Drive request channel
interface pidc_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive;

    modport source (
        output valid, drive,
        input  ready
    );

    modport sink (
        input  valid, drive,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/multi_mode_pid_controller.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Multi-mode PID controller on signed fixed-point words (DATA_WIDTH bits,
// FRAC_BITS fraction bits). One request on meas gives one drive on cmd. The
// three products go one after another through a bit-serial multiplier that
// retires one multiplier bit per cycle; the saturating sums and clamps
// follow as registered states. Deadband, forced-output and unused-mode steps
// skip the products and go from the decision straight to the drive request,
// clear requests (func=1) straight from accept. One sample is processed at a
// time; a new sample is taken while the previous drive still waits on cmd.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only
// while no step is in flight; the block itself does not enforce this.
module multi_mode_pid_controller #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    pidc_in_if.sink                                 meas,
    pidc_out_if.source                              cmd,
    input  wire logic                               cfg_we,
    input  wire logic [pidc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [DATA_WIDTH-1:0]              cfg_data
);

    import pidc_pkg::*;

    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [63:0] SMAX64   = 64'((65'(1) << (DATA_WIDTH - 1)) - 65'(1));
    localparam logic [63:0] RAW_ONE  = 64'(1) << FRAC_BITS;
    localparam logic [63:0] RAW_BAND = 64'(20) << FRAC_BITS;
    localparam logic [63:0] RAW_BIG  = 64'(1000) << FRAC_BITS;
    localparam logic [63:0] RAW_FRC  = 64'(3000) << FRAC_BITS;

    // Thresholds in fixed-point scale, saturated to the word range
    localparam logic signed [DATA_WIDTH-1:0] LVL_ONE =
        DATA_WIDTH'((RAW_ONE > SMAX64) ? SMAX64 : RAW_ONE);
    localparam logic signed [DATA_WIDTH-1:0] LVL_BAND =
        DATA_WIDTH'((RAW_BAND > SMAX64) ? SMAX64 : RAW_BAND);
    localparam logic signed [DATA_WIDTH-1:0] LVL_BIG =
        DATA_WIDTH'((RAW_BIG > SMAX64) ? SMAX64 : RAW_BIG);
    localparam logic signed [DATA_WIDTH-1:0] LVL_FRC =
        DATA_WIDTH'((RAW_FRC > SMAX64) ? SMAX64 : RAW_FRC);
    localparam logic signed [DATA_WIDTH-1:0] NEG_ONE  = -LVL_ONE;
    localparam logic signed [DATA_WIDTH-1:0] NEG_BAND = -LVL_BAND;
    localparam logic signed [DATA_WIDTH-1:0] NEG_BIG  = -LVL_BIG;
    localparam logic signed [DATA_WIDTH-1:0] NEG_FRC  = -LVL_FRC;

    // Saturating add
    function automatic logic signed [DATA_WIDTH-1:0] sat_add(
        input logic signed [DATA_WIDTH-1:0] x,
        input logic signed [DATA_WIDTH-1:0] y
    );
        logic signed [DATA_WIDTH:0] s;
        s = {x[DATA_WIDTH-1], x} + {y[DATA_WIDTH-1], y};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
        begin
            sat_add = s[DATA_WIDTH] ? SMIN : SMAX;
        end
        else
        begin
            sat_add = s[DATA_WIDTH-1:0];
        end
    endfunction

    // Saturating subtract
    function automatic logic signed [DATA_WIDTH-1:0] sat_sub(
        input logic signed [DATA_WIDTH-1:0] x,
        input logic signed [DATA_WIDTH-1:0] y
    );
        logic signed [DATA_WIDTH:0] s;
        s = {x[DATA_WIDTH-1], x} - {y[DATA_WIDTH-1], y};
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
        begin
            sat_sub = s[DATA_WIDTH] ? SMIN : SMAX;
        end
        else
        begin
            sat_sub = s[DATA_WIDTH-1:0];
        end
    endfunction

    // Symmetric clamp to +-lim
    function automatic logic signed [DATA_WIDTH-1:0] clamp_lim(
        input logic signed [DATA_WIDTH-1:0] v,
        input logic [DATA_WIDTH-2:0]        lim
    );
        logic signed [DATA_WIDTH-1:0] hi;
        logic signed [DATA_WIDTH-1:0] lo;
        hi = {1'b0, lim};
        lo = -hi;
        if (v > hi)
        begin
            clamp_lim = hi;
        end
        else if (v < lo)
        begin
            clamp_lim = lo;
        end
        else
        begin
            clamp_lim = v;
        end
    endfunction

    // Configuration registers
    pidc_mode_t                   mode_reg;
    logic signed [DATA_WIDTH-1:0] gain_p_reg;
    logic signed [DATA_WIDTH-1:0] gain_i_reg;
    logic signed [DATA_WIDTH-1:0] gain_d_reg;
    logic [DATA_WIDTH-2:0]        olim_reg;
    logic [DATA_WIDTH-2:0]        ilim_reg;

    // Control and loop state
    pidc_state_t                  state_reg, state_next;
    pidc_mul_slot_t               slot_reg, slot_next;
    logic signed [DATA_WIDTH-1:0] error_last_reg, error_last_next;
    logic signed [DATA_WIDTH-1:0] error_before_reg, error_before_next;
    logic signed [DATA_WIDTH-1:0] integral_reg, integral_next;
    logic signed [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                         cmd_valid_reg;

    // Working payload
    logic signed [DATA_WIDTH-1:0] sp_reg, sp_next;
    logic signed [DATA_WIDTH-1:0] fb_reg, fb_next;
    logic signed [DATA_WIDTH-1:0] ext_reg, ext_next;
    logic signed [DATA_WIDTH-1:0] err_reg, err_next;
    logic signed [DATA_WIDTH-1:0] diffb_reg, diffb_next;
    logic signed [DATA_WIDTH-1:0] d1_reg, d1_next;
    logic signed [DATA_WIDTH-1:0] d2_reg, d2_next;
    logic signed [DATA_WIDTH-1:0] p_reg, p_next;
    logic signed [DATA_WIDTH-1:0] ip_reg, ip_next;
    logic signed [DATA_WIDTH-1:0] d_reg, d_next;
    logic signed [DATA_WIDTH-1:0] sum_reg, sum_next;
    logic signed [DATA_WIDTH-1:0] res_reg, res_next;
    logic signed [DATA_WIDTH-1:0] drive_reg;

    // Multiplier hookup
    logic                         mul_start;
    logic signed [DATA_WIDTH-1:0] mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic                         mul_done;
    logic signed [DATA_WIDTH-1:0] mul_prod;

    logic                         out_load;
    logic                         uses_integ_clamp;

    pidc_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign meas.ready = (state_reg == ST_IDLE);
    assign cmd.valid  = cmd_valid_reg;
    assign cmd.drive  = drive_reg;
    assign out_load   = (state_reg == ST_DONE) && (!cmd_valid_reg || cmd.ready);

    assign uses_integ_clamp = (mode_reg == MODE_POSITIONAL) || (mode_reg == MODE_POS_DELTA)
                           || (mode_reg == MODE_CHASSIS);

    // Multiplier operand selection per mode and slot
    always_comb
    begin
        case (slot_reg)
            MUL_P:
            begin
                mul_a = gain_p_reg;
                if (mode_reg == MODE_INCREMENTAL)
                begin
                    mul_b = d1_reg;
                end
                else if (mode_reg == MODE_PD_GYRO)
                begin
                    mul_b = gain_p_reg;
                end
                else
                begin
                    mul_b = err_reg;
                end
            end
            MUL_I:
            begin
                mul_a = (mode_reg == MODE_PD_GYRO) ? p_reg : gain_i_reg;
                mul_b = err_reg;
            end
            default:
            begin
                mul_a = gain_d_reg;
                if (mode_reg == MODE_INCREMENTAL)
                begin
                    mul_b = d2_reg;
                end
                else if (mode_reg == MODE_PD_GYRO)
                begin
                    mul_b = ext_reg;
                end
                else
                begin
                    mul_b = d1_reg;
                end
            end
        endcase
    end

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        error_last_next   = error_last_reg;
        error_before_next = error_before_reg;
        integral_next     = integral_reg;
        acc_next          = acc_reg;
        sp_next           = sp_reg;
        fb_next           = fb_reg;
        ext_next          = ext_reg;
        err_next          = err_reg;
        diffb_next        = diffb_reg;
        d1_next           = d1_reg;
        d2_next           = d2_reg;
        p_next            = p_reg;
        ip_next           = ip_reg;
        d_next            = d_reg;
        sum_next          = sum_reg;
        res_next          = res_reg;
        mul_start         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (meas.valid)
                begin
                    if (meas.func)
                    begin
                        // Clear request
                        error_last_next   = '0;
                        error_before_next = '0;
                        integral_next     = '0;
                        acc_next          = '0;
                        res_next          = '0;
                        state_next        = ST_DONE;
                    end
                    else
                    begin
                        sp_next    = meas.setpoint;
                        fb_next    = meas.feedback;
                        ext_next   = meas.external_derivative;
                        state_next = ST_ERR;
                    end
                end
            end
            ST_ERR:
            begin
                err_next   = sat_sub(sp_reg, fb_reg);
                diffb_next = sat_sub(error_before_reg, error_last_reg);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                // First difference, then shift the error history
                d1_next           = sat_sub(err_reg, error_last_reg);
                error_before_next = error_last_reg;
                error_last_next   = err_reg;
                state_next        = ST_DIFF2;
            end
            ST_DIFF2:
            begin
                d2_next    = sat_add(d1_reg, diffb_reg);
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                slot_next  = MUL_P;
                state_next = ST_MUL_START;
                case (mode_reg)
                    MODE_POSITIONAL, MODE_INCREMENTAL:
                    begin
                        state_next = ST_MUL_START;
                    end
                    MODE_PD_GYRO:
                    begin
                        if ((err_reg < LVL_ONE) && (err_reg > NEG_ONE))
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                    end
                    MODE_POS_DELTA:
                    begin
                        if ((err_reg < LVL_BAND) && (err_reg > NEG_BAND))
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                        else if (err_reg > LVL_BIG)
                        begin
                            acc_next   = '0;
                            res_next   = LVL_FRC;
                            state_next = ST_DONE;
                        end
                        else if (err_reg < NEG_BIG)
                        begin
                            acc_next   = '0;
                            res_next   = NEG_FRC;
                            state_next = ST_DONE;
                        end
                    end
                    MODE_CHASSIS:
                    begin
                        if ((err_reg < LVL_BAND) && (err_reg > NEG_BAND))
                        begin
                            res_next   = '0;
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        // Unused mode codes report the held accumulator
                        res_next   = acc_reg;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MUL_START:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    case (slot_reg)
                        MUL_P:
                        begin
                            p_next = mul_prod;
                        end
                        MUL_I:
                        begin
                            if (mode_reg == MODE_PD_GYRO)
                            begin
                                p_next = mul_prod;
                            end
                            else
                            begin
                                ip_next = mul_prod;
                            end
                        end
                        default:
                        begin
                            d_next = mul_prod;
                        end
                    endcase
                    if (slot_reg == MUL_D)
                    begin
                        state_next = ST_INTEG;
                    end
                    else
                    begin
                        slot_next  = pidc_mul_slot_t'(slot_reg + 2'd1);
                        state_next = ST_MUL_START;
                    end
                end
            end
            ST_INTEG:
            begin
                if (mode_reg == MODE_INCREMENTAL)
                begin
                    integral_next = ip_reg;
                end
                sum_next   = sat_add(integral_reg, ip_reg);
                state_next = ST_INTEG_CLAMP;
            end
            ST_INTEG_CLAMP:
            begin
                if (uses_integ_clamp)
                begin
                    integral_next = clamp_lim(sum_reg, ilim_reg);
                end
                state_next = ST_SUM_PI;
            end
            ST_SUM_PI:
            begin
                sum_next   = sat_add(p_reg, integral_reg);
                state_next = ST_SUM_D;
            end
            ST_SUM_D:
            begin
                sum_next   = sat_add(sum_reg, d_reg);
                state_next = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                if ((mode_reg == MODE_INCREMENTAL) || (mode_reg == MODE_POS_DELTA))
                begin
                    sum_next = sat_add(acc_reg, sum_reg);
                end
                state_next = ST_CLAMP_OUT;
            end
            ST_CLAMP_OUT:
            begin
                acc_next   = clamp_lim(sum_reg, olim_reg);
                res_next   = clamp_lim(sum_reg, olim_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control, loop state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= MUL_P;
            error_last_reg   <= '0;
            error_before_reg <= '0;
            integral_reg     <= '0;
            acc_reg          <= '0;
            cmd_valid_reg    <= 1'b0;
            mode_reg         <= MODE_POSITIONAL;
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            olim_reg         <= '1;
            ilim_reg         <= '1;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            error_last_reg   <= error_last_next;
            error_before_reg <= error_before_next;
            integral_reg     <= integral_next;
            acc_reg          <= acc_next;

            if (out_load)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (cmd.ready)
            begin
                cmd_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_reg   <= pidc_mode_t'(cfg_data[2:0]);
                    CFG_GAIN_P: gain_p_reg <= cfg_data;
                    CFG_GAIN_I: gain_i_reg <= cfg_data;
                    CFG_GAIN_D: gain_d_reg <= cfg_data;
                    CFG_OLIM:   olim_reg   <= cfg_data[DATA_WIDTH-2:0];
                    CFG_ILIM:   ilim_reg   <= cfg_data[DATA_WIDTH-2:0];
                    default:    ;
                endcase
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        sp_reg    <= sp_next;
        fb_reg    <= fb_next;
        ext_reg   <= ext_next;
        err_reg   <= err_next;
        diffb_reg <= diffb_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        p_reg     <= p_next;
        ip_reg    <= ip_next;
        d_reg     <= d_next;
        sum_reg   <= sum_next;
        res_reg   <= res_next;
        if (out_load)
        begin
            drive_reg <= res_reg;
        end
    end

    `PIDC_ASSERT(a_done_in_wait, mul_done |-> (state_reg == ST_MUL_WAIT), "product outside wait")
    `PIDC_ASSERT(a_clear_state, (meas.valid && meas.ready && meas.func) |=> (error_last_reg == '0 && integral_reg == '0 && acc_reg == '0), "clear request left state")
    `PIDC_ASSERT(a_drive_issue, (state_reg == ST_DONE && !cmd_valid_reg) |=> cmd.valid, "finished step not issued")
    `PIDC_ASSERT(a_idle_after_load, out_load |=> (state_reg == ST_IDLE), "sequencer not idle after issue")

endmodule

`default_nettype wire

FILE: hw/rtl/pidc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Bit-serial fixed-point multiplier: (a * b) >> FRAC_BITS, truncated toward
// zero and saturated. Sign-magnitude, one multiplier bit per cycle.
module pidc_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [DATA_WIDTH-1:0] a,
    input  wire logic signed [DATA_WIDTH-1:0] b,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      product
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_WIDTH - 1);
    localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                         run_reg;
    logic                         fin_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             count_reg;
    logic                         neg_reg;
    logic [DATA_WIDTH-1:0]        mcand_reg;
    logic [DATA_WIDTH-1:0]        hi_reg;
    logic [DATA_WIDTH-1:0]        lo_reg;
    logic signed [DATA_WIDTH-1:0] product_reg;

    logic [DATA_WIDTH-1:0]        a_u;
    logic [DATA_WIDTH-1:0]        b_u;
    logic [DATA_WIDTH-1:0]        mag_a;
    logic [DATA_WIDTH-1:0]        mag_b;
    logic [DATA_WIDTH:0]          step_sum;
    logic [2*DATA_WIDTH-1:0]      full;
    logic [2*DATA_WIDTH-1:0]      shifted;
    logic                         ovf;
    logic [DATA_WIDTH-1:0]        pos_val;
    logic [DATA_WIDTH-1:0]        neg_val;
    logic signed [DATA_WIDTH-1:0] result_next;

    // Operand magnitudes; the most negative value maps to 2^(W-1)
    assign a_u   = a;
    assign b_u   = b;
    assign mag_a = a[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
    assign mag_b = b[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;

    // One shift-add step
    assign step_sum = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? mcand_reg : '0)};

    // Scale, saturate and restore sign
    assign full    = {hi_reg, lo_reg};
    assign shifted = full >> FRAC_BITS;
    assign ovf     = |shifted[2*DATA_WIDTH-1:DATA_WIDTH-1];
    assign pos_val = {1'b0, shifted[DATA_WIDTH-2:0]};
    assign neg_val = ~pos_val + 1'b1;

    always_comb
    begin
        if (neg_reg)
        begin
            result_next = ovf ? SMIN : neg_val;
        end
        else
        begin
            result_next = ovf ? SMAX : pos_val;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= run_reg && (count_reg == LAST_BIT);
            if (start)
            begin
                run_reg   <= 1'b1;
                count_reg <= '0;
            end
            else if (run_reg)
            begin
                if (count_reg == LAST_BIT)
                begin
                    run_reg <= 1'b0;
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            mcand_reg <= mag_a;
            lo_reg    <= mag_b;
            hi_reg    <= '0;
        end
        else if (run_reg)
        begin
            hi_reg <= step_sum[DATA_WIDTH:1];
            lo_reg <= {step_sum[0], lo_reg[DATA_WIDTH-1:1]};
        end
        if (fin_reg)
        begin
            product_reg <= result_next;
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

    `PIDC_NEVER(a_run_and_fin, run_reg && fin_reg, "multiplier finished while still running")
    `PIDC_ASSERT(a_fin_done, fin_reg |=> done_reg, "finish not followed by done")
    `PIDC_ASSERT(a_done_pulse, done_reg |=> !done_reg, "done held longer than one cycle")

endmodule

`default_nettype wire
